### rtl/core/rsi_pkg.sv
// shared types, constants and helpers for the row shear interpolator
`timescale 1ns / 1ps
package rsi_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;

    localparam int DIM_W       = 12;   // width and height registers
    localparam int IDX_W       = 11;   // column and row counters
    localparam int COL_W       = 13;   // destination column, wraps
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 4;
    localparam int PIX_W       = CHAN_W * NUM_CHAN;
    localparam int OUT_DATA_W  = 56;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam int DIV_NUM_W   = 19;
    localparam int DIV_DEN_W   = 11;
    localparam int DIV_CNT_W   = 5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam logic [1:0] REG_ROW_WIDTH    = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [1:0] REG_SHEAR_OFFSET = 2'd2;

    typedef enum logic [2:0] {
        SU_LOAD,
        SU_DIV_S,
        SU_PREP,
        SU_DIV_R,
        SU_READY
    } t_su_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
        logic [DIV_DEN_W-1:0] rem;
    } t_div_rsp;

    // one classified pixel on its way to the blend stage
    typedef struct packed {
        logic [COL_W-1:0]                 col;
        logic [IDX_W-1:0]                 row;
        logic [NUM_CHAN-1:0][CHAN_W-1:0]  pix;
        logic [CHAN_W-1:0]                wl;
        logic                             first;
        logic                             last;
        logic                             frac;
    } t_item;

    // floor(x/255) for x up to 255*255
    function automatic logic [CHAN_W-1:0] div255(input logic [16:0] x);
        logic [17:0] y;
        y = 18'(x) + 18'(x[16:8]) + 18'd1;
        return y[15:8];
    endfunction

endpackage

### rtl/core/row_shear_interpolator_core.sv
// top level of the row shear interpolator
// an accepted pixel is queued, then its weight products are registered, then it loads the output register
// throughput: one pixel per cycle when not stalled; a fractional row adds a trailing pixel
// setup: after reset and after every register write, s_tready stays low while
//   two 19-step divisions work out the per-row increments; a single-row image skips them
// reset: synchronous, active low; clears handshake and control state, registers to 1, 1, 0
`timescale 1ns / 1ps
module row_shear_interpolator_core
    import rsi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [PIX_W-1:0]      i_s_tdata,   // red, green, blue, alpha
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // out_column, out_row, out_red, out_green, out_blue, out_alpha
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast    // row_end
);

    t_div_req div_req;
    t_div_rsp div_rsp;
    logic     push;
    t_item    push_item;
    logic     full;
    logic     pop;
    t_item    pop_item;
    logic     empty;

    rsi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_div_req  (div_req),
        .i_div_rsp  (div_rsp),
        .o_push     (push),
        .o_item     (push_item),
        .i_full     (full)
    );

    rsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_empty (empty)
    );

    rsi_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (pop_item),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

### rtl/core/rsi_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rsi_div
    import rsi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   trial;
    logic                 take;

    assign trial = {r_rem, r_quo[DIV_NUM_W-1]};
    assign take  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // a restart drops the result of the division it cuts short
            r_done <= r_busy && (r_cnt == '0) && !i_req.start;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= take ? DIV_DEN_W'(trial - {1'b0, r_den}) : trial[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], take};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

### rtl/core/rsi_queue.sv
// short queue of classified pixels between front and back
`timescale 1ns / 1ps
module rsi_queue
    import rsi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_full  = r_count == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/core/rsi_front.sv
// config registers, per-image setup and per-pixel row/column classification
`timescale 1ns / 1ps
module rsi_front
    import rsi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [PIX_W-1:0]      i_s_tdata,   // red, green, blue, alpha
    output t_div_req              o_div_req,
    input  t_div_rsp              i_div_rsp,
    output logic                  o_push,
    output t_item                 o_item,
    input  logic                  i_full
);

    logic [DIM_W-1:0]     r_cfg_width;
    logic [DIM_W-1:0]     r_cfg_count;
    logic [COL_W-1:0]     r_cfg_shear;

    t_su_state            r_state;
    t_su_state            n_state;

    // per-image constants
    logic [DIV_DEN_W-1:0] r_d;
    logic [COL_W-1:0]     r_base;
    logic [COL_W-1:0]     r_qinit;
    logic [COL_W-1:0]     r_qs;
    logic [DIV_DEN_W-1:0] r_rs;
    logic [CHAN_W-1:0]    r_ar;
    logic [DIV_DEN_W-1:0] r_br;

    // per-row tracking of the shift quotient/remainder and the weight terms
    logic [IDX_W-1:0]     r_row;
    logic [IDX_W-1:0]     r_col;
    logic [COL_W-1:0]     r_q;
    logic [DIV_DEN_W-1:0] r_r;
    logic [CHAN_W-1:0]    r_a;
    logic [DIV_DEN_W-1:0] r_b;

    logic                 cfg_wr;
    logic [DIM_W-1:0]     w_eff;
    logic [DIM_W-1:0]     h_eff;
    logic                 multi_row;
    logic                 s_neg;
    logic [COL_W-1:0]     s_mag;
    logic [DIV_DEN_W-1:0] d_now;
    logic                 in_fire;
    logic                 last_col;
    logic                 last_row;
    logic                 wrap;
    logic                 bb;
    logic                 frac;
    logic [DIV_NUM_W-1:0] rs255;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_ROW_WIDTH:    prdata = APB_DATA_W'(r_cfg_width);
            REG_ROW_COUNT:    prdata = APB_DATA_W'(r_cfg_count);
            REG_SHEAR_OFFSET: prdata = APB_DATA_W'(r_cfg_shear);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width <= DIM_W'(1);
            r_cfg_count <= DIM_W'(1);
            r_cfg_shear <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_ROW_WIDTH:    r_cfg_width <= pwdata[DIM_W-1:0];
                REG_ROW_COUNT:    r_cfg_count <= pwdata[DIM_W-1:0];
                REG_SHEAR_OFFSET: r_cfg_shear <= pwdata[COL_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (r_cfg_width > DIM_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = r_cfg_width;
        end
        if (r_cfg_count == '0) begin
            h_eff = DIM_W'(1);
        end else if (r_cfg_count > DIM_W'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_cfg_count;
        end
    end

    assign multi_row = h_eff > DIM_W'(1);
    assign s_neg     = r_cfg_shear[COL_W-1];
    assign s_mag     = s_neg ? COL_W'(-r_cfg_shear) : r_cfg_shear;
    assign d_now     = DIV_DEN_W'(h_eff - DIM_W'(1));
    assign rs255     = DIV_NUM_W'({r_rs, 8'd0}) - DIV_NUM_W'(r_rs);

    // setup state machine
    always_comb begin
        case (r_state)
            SU_LOAD:  n_state = multi_row ? SU_DIV_S : SU_READY;
            SU_DIV_S: n_state = i_div_rsp.done ? SU_PREP : SU_DIV_S;
            SU_PREP:  n_state = SU_DIV_R;
            SU_DIV_R: n_state = i_div_rsp.done ? SU_READY : SU_DIV_R;
            SU_READY: n_state = SU_READY;
            default:  n_state = SU_LOAD;
        endcase
        if (cfg_wr) begin
            n_state = SU_LOAD;
        end
    end

    always_comb begin
        o_div_req = '0;
        case (r_state)
            SU_LOAD: begin
                o_div_req.start = multi_row;
                o_div_req.num   = DIV_NUM_W'(s_mag);
                o_div_req.den   = d_now;
            end
            SU_PREP: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = rs255;
                o_div_req.den   = r_d;
            end
            default: ;
        endcase
        o_s_tready = (r_state == SU_READY) && !i_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SU_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign in_fire  = i_s_tvalid && o_s_tready;
    assign last_col = r_col == IDX_W'(w_eff - DIM_W'(1));
    assign last_row = r_row == IDX_W'(h_eff - DIM_W'(1));
    assign wrap     = r_r < r_rs;
    assign bb       = r_b < r_br;
    assign frac     = r_r != '0;

    // setup data captures
    always_ff @(posedge i_clk) begin
        if (r_state == SU_LOAD) begin
            r_d     <= d_now;
            r_base  <= (multi_row && s_neg) ? s_mag : '0;
            r_qinit <= (!multi_row && s_neg) ? '0 : r_cfg_shear;
            r_qs    <= '0;
            r_rs    <= '0;
            r_ar    <= '0;
            r_br    <= '0;
        end else if (r_state == SU_DIV_S && i_div_rsp.done) begin
            if (!s_neg) begin
                r_qs <= i_div_rsp.quo[COL_W-1:0];
                r_rs <= i_div_rsp.rem;
            end else if (i_div_rsp.rem == '0) begin
                r_qs <= COL_W'(-i_div_rsp.quo[COL_W-1:0]);
                r_rs <= '0;
            end else begin
                r_qs <= ~i_div_rsp.quo[COL_W-1:0];
                r_rs <= r_d - i_div_rsp.rem;
            end
        end else if (r_state == SU_DIV_R && i_div_rsp.done) begin
            r_ar <= i_div_rsp.quo[CHAN_W-1:0];
            r_br <= i_div_rsp.rem;
        end
    end

    // row and column walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (r_state == SU_LOAD) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_fire) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // next row: subtract the per-row step, borrow on remainder wrap; the last row reloads the start values
    always_ff @(posedge i_clk) begin
        if (r_state == SU_LOAD) begin
            r_q <= (!multi_row && s_neg) ? '0 : r_cfg_shear;
            r_r <= '0;
            r_a <= '0;
            r_b <= '0;
        end else if (in_fire && last_col) begin
            if (last_row) begin
                r_q <= r_qinit;
                r_r <= '0;
                r_a <= '0;
                r_b <= '0;
            end else begin
                r_q <= r_q - r_qs - COL_W'(wrap);
                r_r <= r_r - r_rs + (wrap ? r_d : '0);
                r_a <= r_a - r_ar - CHAN_W'(bb) + (wrap ? 8'd255 : 8'd0);
                r_b <= r_b - r_br + (bb ? r_d : '0);
            end
        end
    end

    assign o_push       = in_fire;
    assign o_item.col   = r_q + r_base + COL_W'(r_col);
    assign o_item.row   = r_row;
    assign o_item.pix   = i_s_tdata;
    assign o_item.wl    = frac ? CHAN_W'(8'd255 - r_a - CHAN_W'(r_b != '0)) : 8'd255;
    assign o_item.first = r_col == '0;
    assign o_item.last  = last_col;
    assign o_item.frac  = frac;

endmodule

### rtl/core/rsi_back.sv
// blend stage: weight products, divide by 255, output register with trailing pixel
`timescale 1ns / 1ps
module rsi_back
    import rsi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_item                 i_item,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast
);

    logic [NUM_CHAN-1:0][CHAN_W-1:0] r_prev;

    logic                            r_s1_valid;
    logic [NUM_CHAN-1:0][15:0]       r_s1_prvr;
    logic [NUM_CHAN-1:0][15:0]       r_s1_curl;
    logic [NUM_CHAN-1:0][15:0]       r_s1_curr;
    logic [COL_W-1:0]                r_s1_col;
    logic [IDX_W-1:0]                r_s1_row;
    logic                            r_s1_tail;
    logic                            r_s1_end;

    logic                            r_o_valid;
    logic [OUT_DATA_W-1:0]           r_o_data;
    logic                            r_o_last;
    logic                            r_t_pend;
    logic [OUT_DATA_W-1:0]           r_t_data;

    logic [CHAN_W-1:0]               wr;
    logic [CHAN_W-1:0]               wp;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] main_pix;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] tail_pix;
    logic                            out_free;
    logic                            load;
    logic                            out_fire;

    assign wr       = 8'd255 - i_item.wl;
    assign wp       = i_item.first ? 8'd0 : wr;
    assign out_fire = r_o_valid && i_m_tready;
    assign out_free = !r_o_valid || (i_m_tready && !r_t_pend);
    assign load     = r_s1_valid && out_free;
    assign o_pop    = !i_empty && (!r_s1_valid || load);

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            main_pix[c] = div255(17'(r_s1_prvr[c]) + 17'(r_s1_curl[c]));
            tail_pix[c] = div255(17'(r_s1_curr[c]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_t_pend   <= 1'b0;
            r_prev     <= '0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (load) begin
                r_s1_valid <= 1'b0;
            end
            if (o_pop) begin
                r_prev <= i_item.pix;
            end
            if (load) begin
                r_o_valid <= 1'b1;
                r_t_pend  <= r_s1_tail;
            end else if (out_fire) begin
                // trailing pixel moves up, otherwise the register drains
                r_o_valid <= r_t_pend;
                r_t_pend  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_s1_prvr[c] <= 16'(r_prev[c]) * 16'(wp);
                r_s1_curl[c] <= 16'(i_item.pix[c]) * 16'(i_item.wl);
                r_s1_curr[c] <= 16'(i_item.pix[c]) * 16'(wr);
            end
            r_s1_col  <= i_item.col;
            r_s1_row  <= i_item.row;
            r_s1_tail <= i_item.frac && i_item.last;
            r_s1_end  <= !i_item.frac && i_item.last;
        end
        if (load) begin
            r_o_data <= {main_pix, r_s1_row, r_s1_col};
            r_o_last <= r_s1_end;
            r_t_data <= {tail_pix, r_s1_row, COL_W'(r_s1_col + 1'b1)};
        end else if (out_fire && r_t_pend) begin
            r_o_data <= r_t_data;
            r_o_last <= 1'b1;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;

endmodule

### rtl/core/rsi_checker.sv
// port-level checks for the row shear interpolator, bound to the top level
`timescale 1ns / 1ps
module rsi_checker
    import rsi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_s_tready,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_m_tlast
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))
        else $error("result changed while stalled");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid right after reset");

    // setup runs after reset, so no pixel is taken
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_s_tready)
        else $error("pixel ready right after reset");

    // a register write restarts setup
    a_cfg_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite |=> !i_s_tready)
        else $error("pixel ready right after a register write");

endmodule

bind row_shear_interpolator_core rsi_checker u_rsi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_psel     (psel),
    .i_penable  (penable),
    .i_pwrite   (pwrite),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tlast  (o_m_tlast)
);
